// File: rtl/lvm_pkg.sv
`default_nettype none
package lvm_pkg;

    localparam int ELEM_W = 32;
    localparam int NROWS  = 4;
    localparam int NCOLS  = 4;
    localparam int COL_W  = 2;
    localparam int IN_W   = 6 * ELEM_W;
    // column_index, four rows, zero fill to whole bytes
    localparam int OUT_W  = 136;
    localparam int PAD_W  = OUT_W - COL_W - NROWS * ELEM_W;

    localparam logic [COL_W-1:0]  LAST_COL = 2'd3;
    localparam logic [ELEM_W-1:0] SAT_MAX  = 32'h7fff_ffff;
    localparam logic [ELEM_W-1:0] SAT_MIN  = 32'h8000_0000;

    // one view matrix, column-major, plus the degenerate flag
    typedef struct packed {
        logic                                      degen;
        logic [NCOLS-1:0][NROWS-1:0][ELEM_W-1:0]   col;
    } mat_t;

endpackage
`default_nettype wire

// File: rtl/lookat_view_matrix.sv
// Look-at view matrix generator.
// Input stream (s_t*): one transaction carries a camera position and a look-at
// point, six signed fixed-point words with FRAC_BITS fraction bits.
// Output stream (m_t*): four transactions per input, one matrix column each in
// column order; tlast marks column 3, tuser flags a degenerate view (zero
// direction or direction along the up axis), in which case all elements are 0.
// Most of the pipeline lies in three normalization units: each has a six-stage
// shift normalizer, a square and sum, a 32-stage square root (one root bit per
// stage) and a FRAC_BITS+1 stage divider.
// The pipeline takes a new input every cycle while not stalled; the single output
// channel carries each matrix as four column transactions, so it bounds the
// sustained input rate. A column serializer holds the finished matrix, so the
// pipeline keeps moving while a result waits.
// Stall: when a finished matrix waits and the serializer cannot take it yet, the
// whole pipeline freezes together with s_tready; nothing is lost or repeated.
// Reset: all valid bits and the serializer clear; no item is in flight.
`default_nettype none
module lookat_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z
    input  logic [lvm_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // column_index, elem_row0, elem_row1, elem_row2, elem_row3, zero fill
    output logic [lvm_pkg::OUT_W-1:0] m_tdata,
    // degenerate
    output logic [0:0]                m_tuser,
    output logic                      m_tlast
);
    import lvm_pkg::*;

    localparam int UW  = FRAC_BITS + 2;
    localparam int CW  = 2 * UW + 1;
    localparam int PW  = UW + ELEM_W;
    localparam int DW  = PW + 2;
    localparam int RSW = DW + 1 - FRAC_BITS;
    localparam int EYW = 3 * ELEM_W;
    localparam int SWB = EYW + 3 * UW + 1;
    localparam int SWC = EYW + 6 * UW + 1;

    logic adv;
    logic col_ready;
    logic mat_valid_reg;
    mat_t mat_reg;
    mat_t mat_next;

    // one enable for every stage: advance unless the finished matrix is stuck
    assign adv      = !mat_valid_reg || col_ready;
    assign s_tready = adv;

    // capture the input and form target - eye
    logic                    v0_reg;
    logic [EYW-1:0]          eye0_reg;
    logic signed [ELEM_W:0]  d0_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            eye0_reg <= s_tdata[EYW-1:0];
            for (int i = 0; i < 3; i++)
            begin
                d0_reg[i] <= (ELEM_W+1)'($signed(s_tdata[(i+3)*ELEM_W +: ELEM_W]))
                           - (ELEM_W+1)'($signed(s_tdata[i*ELEM_W +: ELEM_W]));
            end
        end
    end

    // view direction
    logic                 va;
    logic signed [UW-1:0] dir_a [3];
    logic                 nz_a;
    logic [EYW-1:0]       side_a;

    lvm_unit3 #(
        .IW(ELEM_W + 1),
        .F (FRAC_BITS),
        .SW(EYW)
    ) u_dir (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (v0_reg),
        .in_vec   (d0_reg),
        .in_side  (eye0_reg),
        .out_valid(va),
        .out_vec  (dir_a),
        .out_nz   (nz_a),
        .out_side (side_a)
    );

    // right = normalize(dir x up) with up = (0,1,0)
    logic signed [UW:0] rv [3];
    logic               degen_a;

    assign degen_a = !nz_a || (dir_a[0] == '0 && dir_a[2] == '0);
    assign rv[0]   = -((UW+1)'(dir_a[2]));
    assign rv[1]   = '0;
    assign rv[2]   = (UW+1)'(dir_a[0]);

    logic                 vb;
    logic signed [UW-1:0] rt_b [3];
    logic                 nz_b;
    logic [SWB-1:0]       side_b;

    lvm_unit3 #(
        .IW(UW + 1),
        .F (FRAC_BITS),
        .SW(SWB)
    ) u_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (va),
        .in_vec   (rv),
        .in_side  ({degen_a, dir_a[2], dir_a[1], dir_a[0], side_a}),
        .out_valid(vb),
        .out_vec  (rt_b),
        .out_nz   (nz_b),
        .out_side (side_b)
    );

    // cross product right x dir: products, then differences
    logic                   v2_reg;
    logic signed [2*UW-1:0] xp_reg [6];
    logic [EYW-1:0]         eye2_reg;
    logic signed [UW-1:0]   dir2_reg [3];
    logic signed [UW-1:0]   rt2_reg [3];
    logic                   dg2_reg;
    logic signed [UW-1:0]   dir_b [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dir_b[i] = $signed(side_b[EYW + i*UW +: UW]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= vb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xp_reg[0] <= rt_b[1] * dir_b[2];
            xp_reg[1] <= dir_b[1] * rt_b[2];
            xp_reg[2] <= rt_b[2] * dir_b[0];
            xp_reg[3] <= dir_b[2] * rt_b[0];
            xp_reg[4] <= rt_b[0] * dir_b[1];
            xp_reg[5] <= dir_b[0] * rt_b[1];
            eye2_reg  <= side_b[EYW-1:0];
            dir2_reg  <= dir_b;
            rt2_reg   <= rt_b;
            dg2_reg   <= side_b[EYW + 3*UW] || !nz_b;
        end
    end

    logic                 v3_reg;
    logic signed [CW-1:0] cv_reg [3];
    logic [EYW-1:0]       eye3_reg;
    logic signed [UW-1:0] dir3_reg [3];
    logic signed [UW-1:0] rt3_reg [3];
    logic                 dg3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cv_reg[i] <= CW'(xp_reg[2*i]) - CW'(xp_reg[2*i+1]);
            end
            eye3_reg <= eye2_reg;
            dir3_reg <= dir2_reg;
            rt3_reg  <= rt2_reg;
            dg3_reg  <= dg2_reg;
        end
    end

    // corrected up vector
    logic                 vc;
    logic signed [UW-1:0] up_c [3];
    logic                 nz_c;
    logic [SWC-1:0]       side_c;

    lvm_unit3 #(
        .IW(CW),
        .F (FRAC_BITS),
        .SW(SWC)
    ) u_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (v3_reg),
        .in_vec   (cv_reg),
        .in_side  ({dg3_reg, rt3_reg[2], rt3_reg[1], rt3_reg[0],
                    dir3_reg[2], dir3_reg[1], dir3_reg[0], eye3_reg}),
        .out_valid(vc),
        .out_vec  (up_c),
        .out_nz   (nz_c),
        .out_side (side_c)
    );

    // translation: dot products with the eye position
    logic signed [ELEM_W-1:0] eye_c [3];
    logic signed [UW-1:0]     dir_c [3];
    logic signed [UW-1:0]     rt_c [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye_c[i] = $signed(side_c[i*ELEM_W +: ELEM_W]);
            dir_c[i] = $signed(side_c[EYW + i*UW +: UW]);
            rt_c[i]  = $signed(side_c[EYW + 3*UW + i*UW +: UW]);
        end
    end

    logic                 v4_reg;
    logic signed [PW-1:0] dp_reg [9];
    logic signed [UW-1:0] rt4_reg [3];
    logic signed [UW-1:0] up4_reg [3];
    logic signed [UW-1:0] dir4_reg [3];
    logic                 dg4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= vc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp_reg[i]   <= rt_c[i] * eye_c[i];
                dp_reg[3+i] <= up_c[i] * eye_c[i];
                dp_reg[6+i] <= dir_c[i] * eye_c[i];
            end
            rt4_reg  <= rt_c;
            up4_reg  <= up_c;
            dir4_reg <= dir_c;
            dg4_reg  <= side_c[EYW + 6*UW] || !nz_c;
        end
    end

    logic                 v5_reg;
    logic signed [DW-1:0] xs_reg [3];
    logic signed [UW-1:0] rt5_reg [3];
    logic signed [UW-1:0] up5_reg [3];
    logic signed [UW-1:0] dir5_reg [3];
    logic                 dg5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xs_reg[0] <= -(DW'(dp_reg[0]) + DW'(dp_reg[1]) + DW'(dp_reg[2]));
            xs_reg[1] <= -(DW'(dp_reg[3]) + DW'(dp_reg[4]) + DW'(dp_reg[5]));
            xs_reg[2] <= DW'(dp_reg[6]) + DW'(dp_reg[7]) + DW'(dp_reg[8]);
            rt5_reg   <= rt4_reg;
            up5_reg   <= up4_reg;
            dir5_reg  <= dir4_reg;
            dg5_reg   <= dg4_reg;
        end
    end

    // round half up, saturate, assemble the matrix
    logic signed [DW:0]   yr [3];
    logic [RSW-1:0]       rr [3];
    logic [ELEM_W-1:0]    tr [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            yr[i] = (DW+1)'(xs_reg[i]) + ((DW+1)'(1) <<< (FRAC_BITS - 1));
            rr[i] = yr[i][DW:FRAC_BITS];
            if ((&rr[i][RSW-1:ELEM_W-1]) || !(|rr[i][RSW-1:ELEM_W-1]))
            begin
                tr[i] = rr[i][ELEM_W-1:0];
            end
            else
            begin
                tr[i] = rr[i][RSW-1] ? SAT_MIN : SAT_MAX;
            end
        end
    end

    always_comb
    begin
        mat_next       = '0;
        mat_next.degen = dg5_reg;
        if (!dg5_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mat_next.col[k][0] = ELEM_W'(rt5_reg[k]);
                mat_next.col[k][1] = ELEM_W'(up5_reg[k]);
                mat_next.col[k][2] = ELEM_W'(-((UW+1)'(dir5_reg[k])));
                mat_next.col[k][3] = '0;
            end
            mat_next.col[3][0] = tr[0];
            mat_next.col[3][1] = tr[1];
            mat_next.col[3][2] = tr[2];
            mat_next.col[3][3] = ELEM_W'(1) << FRAC_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mat_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mat_reg <= mat_next;
        end
    end

    // emit one column per output transaction
    lvm_colser u_colser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_valid(mat_valid_reg),
        .load_ready(col_ready),
        .mat       (mat_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // columns of one matrix come in order
    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tdata[COL_W-1:0] == $past(m_tdata[COL_W-1:0]) + COL_W'(1))
        else $error("column index did not advance within a matrix");

    // degenerate matrix carries only zero elements
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[COL_W +: NROWS*ELEM_W] == '0)
        else $error("degenerate column with nonzero elements");

    // flag is shared by all four columns
    a_degen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> $stable(m_tuser))
        else $error("degenerate flag changed inside a matrix");

    // an empty serializer never blocks the input
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output idle");

endmodule
`default_nettype wire

// File: rtl/lvm_isqrt.sv
`default_nettype none
module lvm_isqrt #(
    parameter int VW = 64,
    parameter int SW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [VW-1:0]       in_val,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic [VW/2-1:0]     out_root,
    output logic [SW-1:0]       out_side
);
    localparam int RW = VW / 2;

    logic [VW-1:0] rem_reg  [1:RW];
    logic [RW-1:0] root_reg [1:RW];
    logic [SW-1:0] side_reg [1:RW];
    logic [RW:1]   vld_reg;

    // one result bit per stage, remainder form: rem = value - root^2
    for (genvar j = 0; j < RW; j++) begin : g_step
        localparam int K = RW - 1 - j;
        logic [VW-1:0] rem_cur;
        logic [RW-1:0] root_cur;
        logic [SW-1:0] side_cur;
        logic          v_cur;
        logic [VW:0]   sub;
        logic [VW:0]   remx;
        logic          ge;

        if (j == 0) begin : g_first
            assign rem_cur  = in_val;
            assign root_cur = '0;
            assign side_cur = in_side;
            assign v_cur    = in_valid;
        end else begin : g_next
            assign rem_cur  = rem_reg[j];
            assign root_cur = root_reg[j];
            assign side_cur = side_reg[j];
            assign v_cur    = vld_reg[j];
        end

        assign sub  = ((VW+1)'(root_cur) << (K + 1)) + ((VW+1)'(1) << (2 * K));
        assign remx = {1'b0, rem_cur};
        assign ge   = remx >= sub;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[j+1] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j+1]  <= ge ? VW'(remx - sub) : rem_cur;
                root_reg[j+1] <= ge ? (root_cur | (RW'(1) << K)) : root_cur;
                side_reg[j+1] <= side_cur;
            end
        end
    end

    assign out_valid = vld_reg[RW];
    assign out_root  = root_reg[RW];
    assign out_side  = side_reg[RW];

endmodule
`default_nettype wire

// File: rtl/lvm_unit3.sv
`default_nettype none
module lvm_unit3 #(
    parameter int IW = 33,
    parameter int F  = 16,
    parameter int SW = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic signed [IW-1:0]  in_vec [3],
    input  logic [SW-1:0]         in_side,
    output logic                  out_valid,
    output logic signed [F+1:0]   out_vec [3],
    output logic                  out_nz,
    output logic [SW-1:0]         out_side
);
    localparam int MW   = 64;
    localparam int NL   = 6;
    localparam int MNW  = 31;
    localparam int QB   = F + 1;
    localparam int DVW  = 32 + F;
    localparam int UW   = F + 2;
    localparam int PSW  = SW + 3;
    localparam int ISW  = PSW + 1 + 3 * MNW;

    // magnitudes
    logic [MW-1:0] mag [3];
    logic [2:0]    neg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = in_vec[i][IW-1];
            mag[i] = neg[i] ? MW'(-((IW+1)'(in_vec[i]))) : MW'(in_vec[i]);
        end
    end

    logic [MW-1:0]  sh_reg [0:NL][3];
    logic [MW-1:0]  or_reg [0:NL];
    logic [PSW-1:0] ps_reg [0:NL];
    logic [NL:0]    sv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sh_reg[0][i] <= mag[i];
            end
            or_reg[0] <= mag[0] | mag[1] | mag[2];
            ps_reg[0] <= {in_side, neg};
        end
    end

    // left-justify the common exponent, halving the step each stage
    for (genvar j = 0; j < NL; j++) begin : g_norm
        localparam int SH = MW >> (j + 1);
        logic zero_top;

        assign zero_top = or_reg[j][MW-1 -: SH] == '0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                sv_reg[j+1] <= sv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sh_reg[j+1][i] <= zero_top ? (sh_reg[j][i] << SH) : sh_reg[j][i];
                end
                or_reg[j+1] <= zero_top ? (or_reg[j] << SH) : or_reg[j];
                ps_reg[j+1] <= ps_reg[j];
            end
        end
    end

    // squares: leading one of the largest lands on bit 30
    logic [MNW-1:0]   mn [3];
    logic [2*MNW-1:0] sq_reg [3];
    logic [MNW-1:0]   mq_reg [3];
    logic             nzq_reg;
    logic [PSW-1:0]   psq_reg;
    logic             vq_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mn[i] = sh_reg[NL][i][MW-1 -: MNW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
        end
        else if (adv)
        begin
            vq_reg <= sv_reg[NL];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= mn[i] * mn[i];
                mq_reg[i] <= mn[i];
            end
            nzq_reg <= or_reg[NL] != '0;
            psq_reg <= ps_reg[NL];
        end
    end

    // sum of squares
    logic [MW-1:0]  sum_reg;
    logic [ISW-1:0] isd_reg;
    logic           vs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg <= 1'b0;
        end
        else if (adv)
        begin
            vs_reg <= vq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= MW'(sq_reg[0]) + MW'(sq_reg[1]) + MW'(sq_reg[2]);
            isd_reg <= {psq_reg, nzq_reg, mq_reg[2], mq_reg[1], mq_reg[0]};
        end
    end

    logic              vr;
    logic [MW/2-1:0]   len;
    logic [ISW-1:0]    isd;

    lvm_isqrt #(
        .VW(MW),
        .SW(ISW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (vs_reg),
        .in_val   (sum_reg),
        .in_side  (isd_reg),
        .out_valid(vr),
        .out_root (len),
        .out_side (isd)
    );

    // rounded quotient (m * 2^F + len/2) / len, one bit per stage
    logic [DVW-1:0]  rem_reg [0:QB][3];
    logic [QB-1:0]   q_reg   [0:QB][3];
    logic [MW/2-1:0] len_reg [0:QB];
    logic [PSW:0]    dps_reg [0:QB];
    logic [QB:0]     dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= vr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= (DVW'(isd[i*MNW +: MNW]) << F) + DVW'(len >> 1);
                q_reg[0][i]   <= '0;
            end
            len_reg[0] <= len;
            dps_reg[0] <= isd[ISW-1:3*MNW];
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int K = QB - 1 - j;
        logic [DVW-1:0] dd;

        assign dd = DVW'(len_reg[j]) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[j][i] >= dd)
                    begin
                        rem_reg[j+1][i] <= rem_reg[j][i] - dd;
                        q_reg[j+1][i]   <= q_reg[j][i] | (QB'(1) << K);
                    end
                    else
                    begin
                        rem_reg[j+1][i] <= rem_reg[j][i];
                        q_reg[j+1][i]   <= q_reg[j][i];
                    end
                end
                len_reg[j+1] <= len_reg[j];
                dps_reg[j+1] <= dps_reg[j];
            end
        end
    end

    // restore signs, zero vector gives zero
    logic signed [UW-1:0] out_reg [3];
    logic                 nzo_reg;
    logic [SW-1:0]        sdo_reg;
    logic                 vo_reg;
    logic                 dnz;
    logic [2:0]           dneg;

    assign dnz  = dps_reg[QB][0];
    assign dneg = dps_reg[QB][3:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            vo_reg <= dv_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (!dnz)
                begin
                    out_reg[i] <= '0;
                end
                else if (dneg[i])
                begin
                    out_reg[i] <= -$signed({1'b0, q_reg[QB][i]});
                end
                else
                begin
                    out_reg[i] <= $signed({1'b0, q_reg[QB][i]});
                end
            end
            nzo_reg <= dnz;
            sdo_reg <= dps_reg[QB][PSW:4];
        end
    end

    assign out_valid = vo_reg;
    assign out_vec   = out_reg;
    assign out_nz    = nzo_reg;
    assign out_side  = sdo_reg;

endmodule
`default_nettype wire

// File: rtl/lvm_colser.sv
`default_nettype none
module lvm_colser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load_valid,
    output logic                      load_ready,
    input  lvm_pkg::mat_t             mat,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [lvm_pkg::OUT_W-1:0] m_tdata,
    output logic [0:0]                m_tuser,
    output logic                      m_tlast
);
    import lvm_pkg::*;

    logic             busy_reg;
    logic [COL_W-1:0] cnt_reg;
    mat_t             hold_reg;
    logic             col_last;
    logic             load;

    assign col_last   = cnt_reg == LAST_COL;
    assign load_ready = !busy_reg || (m_tready && col_last);
    assign load       = load_valid && load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg && m_tready)
        begin
            cnt_reg <= cnt_reg + COL_W'(1);
            if (col_last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= mat;
        end
    end

    assign m_tvalid   = busy_reg;
    assign m_tdata    = {{PAD_W{1'b0}}, hold_reg.col[cnt_reg], cnt_reg};
    assign m_tuser[0] = hold_reg.degen;
    assign m_tlast    = col_last;

endmodule
`default_nettype wire

// File: test/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lvm_pkg::*;

    localparam int FRAC = 16;
    // delay from an input transaction to its first output column
    localparam int PIPE_LAT = 3 * FRAC + 139;

    typedef struct {
        logic [COL_W-1:0]  col_idx;
        logic [ELEM_W-1:0] row [NROWS];
        logic              degen;
        logic              last;
    } column_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    // eye_x, eye_y, eye_z, target_x, target_y, target_z
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // column_index, elem_row0, elem_row1, elem_row2, elem_row3, zero fill
    logic [OUT_W-1:0]  m_tdata;
    // degenerate
    logic [0:0]        m_tuser;
    logic              m_tlast;

    column_t column_queue[$];
    int      mismatch_cnt;
    int      send_idle_pct;
    int      recv_stall_pct;

    lookat_view_matrix #(.FRAC_BITS(FRAC)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Integer square root, bit by bit.
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] acc;
        logic [63:0] bit_w;
        acc   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= acc + bit_w)
            begin
                v   = v - (acc + bit_w);
                acc = (acc >> 1) + bit_w;
            end
            else
                acc = acc >> 1;
            bit_w = bit_w >> 2;
        end
        return acc;
    endfunction

    // Scale to a common exponent, then divide each magnitude by the length.
    // Returns 0 for a zero vector.
    function automatic bit normalize(input longint v [3], output longint u [3]);
        logic [63:0] mag [3];
        logic [63:0] peak;
        logic [63:0] sum_sq;
        logic [63:0] len;
        logic [63:0] quo;
        peak = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? -v[i] : v[i];
            if (mag[i] > peak)
                peak = mag[i];
        end
        if (peak == 0)
        begin
            u = '{0, 0, 0};
            return 1'b0;
        end
        while (peak >= (64'd1 << 31))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
            peak = peak >> 1;
        end
        while (peak < (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] << 1;
            peak = peak << 1;
        end
        sum_sq = 0;
        for (int i = 0; i < 3; i++)
            sum_sq = sum_sq + mag[i] * mag[i];
        len = int_sqrt(sum_sq);
        for (int i = 0; i < 3; i++)
        begin
            quo  = ((mag[i] << FRAC) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(quo) : longint'(quo);
        end
        return 1'b1;
    endfunction

    // Drop FRAC fraction bits, rounding half up, and clamp to 32 bits.
    function automatic logic [ELEM_W-1:0] round_clamp(input longint x);
        longint y;
        longint r;
        y = x + (longint'(1) << (FRAC - 1));
        r = y >>> FRAC;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[ELEM_W-1:0];
    endfunction

    // Build the four expected columns of the view matrix for one camera.
    task automatic predict_view_matrix(input logic [IN_W-1:0] cam);
        longint  eye [3];
        longint  diff [3];
        longint  dir [3];
        longint  rv [3];
        longint  right [3];
        longint  cv [3];
        longint  up [3];
        longint  mat [4][4];
        bit      degen;
        column_t c;
        for (int i = 0; i < 3; i++)
        begin
            eye[i]  = longint'($signed(cam[i*ELEM_W +: ELEM_W]));
            diff[i] = longint'($signed(cam[(i+3)*ELEM_W +: ELEM_W])) - eye[i];
        end
        void'(normalize(diff, dir));
        degen = (dir[0] == 0 && dir[2] == 0);
        if (!degen)
        begin
            rv = '{-dir[2], 0, dir[0]};
            if (!normalize(rv, right))
                degen = 1'b1;
        end
        if (!degen)
        begin
            cv[0] = right[1] * dir[2] - dir[1] * right[2];
            cv[1] = right[2] * dir[0] - dir[2] * right[0];
            cv[2] = right[0] * dir[1] - dir[0] * right[1];
            if (!normalize(cv, up))
                degen = 1'b1;
        end
        for (int k = 0; k < 4; k++)
            for (int i = 0; i < 4; i++)
                mat[k][i] = 0;
        if (!degen)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mat[k][0] = right[k];
                mat[k][1] = up[k];
                mat[k][2] = -dir[k];
            end
            mat[3][0] = longint'($signed(round_clamp(
                -(right[0]*eye[0] + right[1]*eye[1] + right[2]*eye[2]))));
            mat[3][1] = longint'($signed(round_clamp(
                -(up[0]*eye[0] + up[1]*eye[1] + up[2]*eye[2]))));
            mat[3][2] = longint'($signed(round_clamp(
                dir[0]*eye[0] + dir[1]*eye[1] + dir[2]*eye[2])));
            mat[3][3] = longint'(1) << FRAC;
        end
        for (int k = 0; k < 4; k++)
        begin
            c.col_idx = k[COL_W-1:0];
            for (int i = 0; i < 4; i++)
                c.row[i] = mat[k][i][ELEM_W-1:0];
            c.degen = degen;
            c.last  = (k == 3);
            column_queue = {column_queue, c};
        end
    endtask

    // Send one camera; hold valid until the transaction completes.
    // Valid drops only while the sender idles, so back-to-back calls keep it high.
    task automatic send_camera(input logic [IN_W-1:0] cam);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cam;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_view_matrix(cam);
        @(negedge clk);
    endtask

    function automatic logic [IN_W-1:0] pack_camera(
        input logic [31:0] ex, input logic [31:0] ey, input logic [31:0] ez,
        input logic [31:0] tx, input logic [31:0] ty, input logic [31:0] tz);
        return {tz, ty, tx, ez, ey, ex};
    endfunction

    // Random coordinate: mostly moderate Q16.16, sometimes anything.
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(3, 0) == 0)
            return $urandom();
        return 32'($signed($urandom_range(2000000, 0)) - 1000000) << $urandom_range(6, 0);
    endfunction

    // Drop valid and hold until every expected column has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (column_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        // plain forward views along the x and z axes, and one oblique view
        send_camera(pack_camera(0, 0, 0, 0, 0, -32'sd65536));
        send_camera(pack_camera(0, 0, 0, 32'sd65536, 0, 0));
        send_camera(pack_camera(32'sd65536, 32'sd131072, 32'sd196608, 0, 0, 0));
        // zero-length direction
        send_camera(pack_camera(32'sd5, 32'sd7, 32'sd9, 32'sd5, 32'sd7, 32'sd9));
        // direction parallel to up, both senses
        send_camera(pack_camera(0, 0, 0, 0, 32'sd65536, 0));
        send_camera(pack_camera(32'sd100, 32'sd3, 32'sd100, 32'sd100, -32'sd900000, 32'sd100));
        // nearly vertical: x, z tiny against y
        send_camera(pack_camera(0, 0, 0, 32'sd1, 32'h7fff_ffff, 0));
        // extremes of the fields, saturating translation
        send_camera(pack_camera(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_camera(pack_camera(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        send_camera(pack_camera(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_camera(pack_camera(32'hffff_ffff, 0, 32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff));
        send_camera(pack_camera(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                                32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
        // smallest nonzero direction
        send_camera(pack_camera(0, 0, 0, 0, 0, 32'sd1));
        send_camera(pack_camera(32'sd1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9, 0) == 0)
                send_camera({$urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom()});
            else
                send_camera(pack_camera(rand_coord(), rand_coord(), rand_coord(),
                                        rand_coord(), rand_coord(), rand_coord()));
        end
    endtask

    // Stall the receiver at the current rate; change ready only at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Check each column transaction against the oldest expectation.
    always @(posedge clk)
    begin
        column_t c;
        bit      bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (column_queue.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected column %h", $realtime, m_tdata);
            end
            else
            begin
                c   = column_queue.pop_front();
                bad = (m_tdata[COL_W-1:0] !== c.col_idx) || (m_tuser[0] !== c.degen)
                    || (m_tlast !== c.last);
                for (int i = 0; i < NROWS; i++)
                    if (m_tdata[COL_W + i*ELEM_W +: ELEM_W] !== c.row[i])
                        bad = 1'b1;
                if (m_tdata[OUT_W-1 -: PAD_W] !== '0)
                    bad = 1'b1;
                if (bad)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: column %0d exp rows %h %h %h %h degen %b last %b, got %h user %b last %b",
                                 $realtime, c.col_idx, c.row[0], c.row[1], c.row[2], c.row[3],
                                 c.degen, c.last, m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    initial
    begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        mismatch_cnt   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        // run back to back, then pause until everything has come out
        test_random(25);
        drain();
        send_idle_pct = 81;
        test_random(25);
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        test_random(25);
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        test_random(25);

        drain();
        recv_stall_pct = 0;
        repeat (PIPE_LAT + 20) @(negedge clk);
        if (mismatch_cnt == 0 && column_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
